// File: rtl/core/tcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_pkg: shared types and constants for the tile change detector
// Transfer payloads, the tile record passed from front to back, and the
// sizes of the hash store and the record queue.
// ----------------------------------------------------------------------------
package tcd_pkg;

	localparam int MAX_TILES = 1024;
	localparam int RAM_AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	// stored word: valid bit above the 64-bit hash
	localparam int RAM_W = 65;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] HASH_SEED = 64'h517C_C1B7_2722_0A95;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic [9:0] tile_number;
		logic       tile_end;
		logic       key_frame;
	} pixel_t;

	typedef struct packed {
		logic [9:0]  tile_id;
		logic        changed;
		logic [63:0] tile_hash;
	} result_t;

	typedef struct packed {
		logic [9:0]  tile_id;
		logic        key;
		logic        in_range;
		logic [63:0] hash;
	} tile_rec_t;

endpackage

// File: rtl/core/tcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_ram: generic single-write, single-read RAM
// One write port and one read port, registered read data, old data on a
// read of the address being written in the same cycle.
// ----------------------------------------------------------------------------
module tcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/tcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_front: byte intake and running hash
// Folds each accepted byte into the running FNV-1a style hash and pushes a
// tile record into the queue on the last byte of a tile.
// ----------------------------------------------------------------------------
module tcd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  tcd_pkg::pixel_t   byte_data,
	input  logic              hold,
	input  logic              q_full,
	output logic              push,
	output tcd_pkg::tile_rec_t push_rec
);

	// xor the byte in, then multiply by 2^40 + 0x1b3 as shifts and adds
	function automatic logic [63:0] fold_byte(logic [63:0] h, logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	logic [63:0] running_q;
	logic [63:0] folded;
	logic        accept;

	assign byte_stall = hold || q_full;
	assign accept     = byte_valid && !byte_stall;
	assign folded     = fold_byte(running_q, byte_data.pixel_byte);
	assign push       = accept && byte_data.tile_end;

	always_comb begin
		push_rec.tile_id  = byte_data.tile_number;
		push_rec.key      = byte_data.key_frame;
		push_rec.in_range = (32'(byte_data.tile_number) < tcd_pkg::MAX_TILES);
		push_rec.hash     = folded;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= tcd_pkg::HASH_SEED;
		end else if (accept) begin
			running_q <= byte_data.tile_end ? tcd_pkg::HASH_SEED : folded;
		end
	end

	a_seed_after_tile: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> running_q == tcd_pkg::HASH_SEED)
		else $error("running hash not back at seed after a tile");

	a_no_accept_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !push)
		else $error("tile record pushed during store clear");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> byte_stall)
		else $error("byte intake open while record queue is full");

endmodule

// File: rtl/core/tcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_queue: tile record queue
// Small flop-based fifo that decouples byte intake from the hash store
// lookup and result output.
// ----------------------------------------------------------------------------
module tcd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tcd_pkg::tile_rec_t push_rec,
	output logic               full,
	input  logic               pop,
	output tcd_pkg::tile_rec_t pop_rec,
	output logic               avail
);

	tcd_pkg::tile_rec_t            entry_q [tcd_pkg::QUEUE_DEPTH];
	logic [tcd_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [tcd_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [tcd_pkg::QUEUE_AW:0]    count_q;

	localparam logic [tcd_pkg::QUEUE_AW-1:0] LAST_PTR =
		tcd_pkg::QUEUE_AW'(tcd_pkg::QUEUE_DEPTH - 1);

	assign full    = (count_q == (tcd_pkg::QUEUE_AW + 1)'(tcd_pkg::QUEUE_DEPTH));
	assign avail   = (count_q != '0);
	assign pop_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full record queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!avail |-> !pop)
		else $error("pop from empty record queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (tcd_pkg::QUEUE_AW + 1)'(tcd_pkg::QUEUE_DEPTH))
		else $error("record queue count out of range");

endmodule

// File: rtl/core/tcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_back: hash store lookup, compare and result output
// Reads the stored hash of each finished tile, decides skip or encode,
// writes the new hash back and holds the result in an output register.
// Clears all valid bits in a sweep after reset.
// ----------------------------------------------------------------------------
module tcd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_avail,
	input  tcd_pkg::tile_rec_t q_rec,
	output logic               q_pop,
	output logic               clearing,
	output logic               tile_valid,
	input  logic               tile_stall,
	output tcd_pkg::result_t   tile_data
);

	logic                         clearing_q;
	logic [tcd_pkg::RAM_AW-1:0]   clr_addr_q;

	logic                         valid_s1;
	tcd_pkg::tile_rec_t           rec_s1;
	logic                         fwd_s1;
	logic [63:0]                  fwd_hash_s1;

	logic                         out_valid_q;
	tcd_pkg::result_t             out_q;

	logic                         advance;
	logic                         wr_tile;
	logic                         ram_we;
	logic [tcd_pkg::RAM_AW-1:0]   ram_waddr;
	logic [tcd_pkg::RAM_W-1:0]    ram_wdata;
	logic [tcd_pkg::RAM_W-1:0]    ram_rdata;
	logic [tcd_pkg::RAM_AW-1:0]   s1_addr;
	logic [tcd_pkg::RAM_AW-1:0]   q_addr;
	logic                         prior_valid;
	logic [63:0]                  prior_hash;
	logic                         changed_s1;

	localparam logic [tcd_pkg::RAM_AW-1:0] LAST_ADDR =
		tcd_pkg::RAM_AW'(tcd_pkg::MAX_TILES - 1);

	assign s1_addr = tcd_pkg::RAM_AW'(rec_s1.tile_id);
	assign q_addr  = tcd_pkg::RAM_AW'(q_rec.tile_id);

	assign advance  = valid_s1 && (!out_valid_q || !tile_stall);
	assign q_pop    = q_avail && !clearing_q && (!valid_s1 || advance);
	assign wr_tile  = advance && rec_s1.in_range;
	assign clearing = clearing_q;

	assign ram_we    = clearing_q || wr_tile;
	assign ram_waddr = clearing_q ? clr_addr_q : s1_addr;
	assign ram_wdata = clearing_q ? '0 : {1'b1, rec_s1.hash};

	tcd_ram #(
		.WIDTH (tcd_pkg::RAM_W),
		.DEPTH (tcd_pkg::MAX_TILES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (q_pop),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	// a write to the same tile in the pop cycle is missed by the read
	assign prior_valid = fwd_s1 || ram_rdata[tcd_pkg::RAM_W-1];
	assign prior_hash  = fwd_s1 ? fwd_hash_s1 : ram_rdata[63:0];
	assign changed_s1  = !(rec_s1.in_range && !rec_s1.key && prior_valid &&
		(prior_hash == rec_s1.hash));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clearing_q <= 1'b0;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!tile_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_s1      <= q_rec;
			fwd_s1      <= wr_tile && (s1_addr == q_addr);
			fwd_hash_s1 <= rec_s1.hash;
		end
		if (advance) begin
			out_q.tile_id   <= rec_s1.tile_id;
			out_q.changed   <= changed_s1;
			out_q.tile_hash <= rec_s1.hash;
		end
	end

	assign tile_valid = out_valid_q;
	assign tile_data  = out_q;

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !q_pop && !valid_s1)
		else $error("tile lookup during store clear");

	a_key_forces_change: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (rec_s1.key || !rec_s1.in_range) |-> changed_s1)
		else $error("skip reported on key frame or out-of-range tile");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("finished tile did not reach the output register");

endmodule

// File: rtl/core/tile_change_detector_fnv1a.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_change_detector_fnv1a: tile change detector, 64-bit FNV-1a style hash
// One pixel byte per cycle unless stalled; a result goes through the record
// queue, lookup and output registers; one result per cycle unless tile_stall.
// The running hash loop (xor then constant multiply as shifts and adds)
// sets the one-byte-per-cycle rate; the hash store has one read, one write.
// After reset, bytes are stalled while the valid bits are swept clear; the
// running hash resets to the seed.
// ----------------------------------------------------------------------------
module tile_change_detector_fnv1a (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  tcd_pkg::pixel_t  byte_data,
	output logic             tile_valid,
	input  logic             tile_stall,
	output tcd_pkg::result_t tile_data
);

	logic               push;
	tcd_pkg::tile_rec_t push_rec;
	logic               q_full;
	logic               q_pop;
	tcd_pkg::tile_rec_t q_rec;
	logic               q_avail;
	logic               clearing;

	tcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.hold       (clearing),
		.q_full     (q_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	tcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.pop_rec  (q_rec),
		.avail    (q_avail)
	);

	tcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (q_avail),
		.q_rec      (q_rec),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.tile_valid (tile_valid),
		.tile_stall (tile_stall),
		.tile_data  (tile_data)
	);

endmodule
